// File: rtl/rrst_pkg.sv
package rrst_pkg;
  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned KeyW = 256;
  localparam logic [31:0] WindowReset = 32'd3600;
  localparam logic [6:0] ScoreMax = 7'd100;

  typedef enum logic [1:0] {
    OpSuccess = 2'd0,
    OpFailure = 2'd1,
    OpRecompute = 2'd2,
    OpQuery = 2'd3
  } op_e;

  typedef struct packed {
    logic start;
    logic [38:0] num;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [6:0] quo;
  } div_rsp_t;
endpackage

// File: rtl/rrst_div.sv
module rrst_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  rrst_pkg::div_req_t req_i,
  output rrst_pkg::div_rsp_t rsp_o
);
  import rrst_pkg::*;

  logic [38:0] rem_q, rem_d;
  logic [33:0] den_q, den_d;
  logic [6:0] quo_q, quo_d;
  logic [2:0] step_q, step_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [40:0] trial;

  // restoring division: quotient fits in 7 bits since num <= 100*den
  always_comb begin
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {2'd0, rem_q} - ({7'd0, den_q} << step_q);
    if (req_i.start) begin
      rem_d = req_i.num;
      den_d = req_i.den;
      quo_d = '0;
      step_d = 3'd6;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[40]) begin
        rem_d = trial[38:0];
        quo_d[step_q] = 1'b1;
      end
      if (step_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q != 3'd0) |=> busy_q)
    else $error("divider stopped early");
endmodule

// File: rtl/relay_reliability_score_table_unit.sv
// channel | dir | handshake             | payload
// cfg     | in  | cfg_valid_i/ready_o   | cfg_data_i (window_seconds)
// in      | in  | in_valid_i/in_ready_o | operation_i, key_word_*_i, is_dns_i, now_seconds_i
// out     | out | out_valid_o/ready_i   | score_o, status_o
// Record and query scan the first entry_count entries in order, reading then comparing
// each one. Recompute reads and evaluates each entry and waits on the divider when a
// score is divided, all on one iterative divider and one memory port per store.
// in_ready_o is low from acceptance until the result transfers on out.
// Reset clears the entry count and sets window_seconds to WindowReset; stores need no clearing.
module relay_reliability_score_table_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [63:0] key_word_0_i,
  input  logic [63:0] key_word_1_i,
  input  logic [63:0] key_word_2_i,
  input  logic [63:0] key_word_3_i,
  input  logic is_dns_i,
  input  logic [31:0] now_seconds_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [6:0] score_o,
  output logic [0:0] status_o
);
  import rrst_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SScanRd, SScanCmp, SRecRd, SRecWr, SRcRd, SRcEval, SRcDiv, SRcWait,
    SOut
  } state_e;

  state_e state_q;
  logic [31:0] win_q;
  logic [CntW-1:0] count_q, idx_q;
  logic [1:0] op_q;
  logic [KeyW-1:0] key_q;
  logic dns_q;
  logic [31:0] now_q;
  logic [6:0] score_q;
  logic status_q;

  logic [KeyW-1:0] key_mem [Entries];
  logic [31:0] att_mem [Entries], suc_mem [Entries], tmo_mem [Entries];
  logic [31:0] dns_mem [Entries], win_mem [Entries];
  logic [6:0] scr_mem [Entries];
  logic [KeyW-1:0] key_rd;
  logic [31:0] att_rd, suc_rd, tmo_rd, dns_rd, win_rd;
  logic [6:0] scr_rd;

  logic [IdxW-1:0] addr;
  logic we;
  logic [31:0] att_wd, suc_wd, tmo_wd, dns_wd, win_wd;
  logic [6:0] scr_wd;
  logic new_ent;

  div_req_t dreq;
  div_rsp_t drsp;
  logic [33:0] den;
  logic [32:0] deadline;

  assign addr = idx_q[IdxW-1:0];
  assign den = {2'd0, suc_rd} + {2'd0, tmo_rd} + {1'b0, dns_rd, 1'b0};
  assign deadline = {1'b0, win_rd} + {1'b0, win_q};

  always_ff @(posedge clk_i) begin
    key_rd <= key_mem[addr];
    att_rd <= att_mem[addr];
    suc_rd <= suc_mem[addr];
    tmo_rd <= tmo_mem[addr];
    dns_rd <= dns_mem[addr];
    win_rd <= win_mem[addr];
    scr_rd <= scr_mem[addr];
    if (we) begin
      att_mem[addr] <= att_wd;
      suc_mem[addr] <= suc_wd;
      tmo_mem[addr] <= tmo_wd;
      dns_mem[addr] <= dns_wd;
      win_mem[addr] <= win_wd;
      scr_mem[addr] <= scr_wd;
      if (new_ent) key_mem[addr] <= key_q;
    end
  end

  rrst_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    we = 1'b0;
    new_ent = 1'b0;
    att_wd = att_rd;
    suc_wd = suc_rd;
    tmo_wd = tmo_rd;
    dns_wd = dns_rd;
    win_wd = win_rd;
    scr_wd = scr_rd;
    dreq.start = 1'b0;
    // 100*succ as 64+32+4 times succ
    dreq.num = {5'd0, suc_rd, 2'b0} + {2'd0, suc_rd, 5'b0} + {1'b0, suc_rd, 6'b0};
    dreq.den = den;
    case (state_q)
      SRecWr: begin
        we = 1'b1;
        new_ent = (idx_q == count_q);
        if (new_ent) begin
          att_wd = '0; suc_wd = '0; tmo_wd = '0; dns_wd = '0;
          win_wd = now_q; scr_wd = ScoreMax;
        end
        att_wd = att_wd + 32'd1;
        if (op_q == OpSuccess) suc_wd = suc_wd + 32'd1;
        else if (dns_q) dns_wd = dns_wd + 32'd1;
        else tmo_wd = tmo_wd + 32'd1;
      end
      SRcEval: begin
        if ({1'b0, now_q} > deadline) begin
          we = 1'b1;
          att_wd = '0; suc_wd = '0; tmo_wd = '0; dns_wd = '0;
          win_wd = now_q; scr_wd = ScoreMax;
        end else if (att_rd == '0 || den == '0) begin
          we = 1'b1;
          scr_wd = ScoreMax;
        end else begin
          dreq.start = 1'b1;
        end
      end
      SRcWait: begin
        we = drsp.done;
        scr_wd = drsp.quo;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      win_q <= WindowReset;
      count_q <= '0;
      idx_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) win_q <= cfg_data_i;
      case (state_q)
        SIdle: if (in_valid_i) begin
          op_q <= operation_i;
          key_q <= {key_word_3_i, key_word_2_i, key_word_1_i, key_word_0_i};
          dns_q <= is_dns_i;
          now_q <= now_seconds_i;
          score_q <= '0;
          status_q <= 1'b0;
          idx_q <= '0;
          state_q <= (operation_i == OpRecompute) ? SRcRd : SScanRd;
        end
        SScanRd: begin
          if (idx_q == count_q) begin
            // key unknown
            if (op_q == OpQuery) begin
              score_q <= ScoreMax;
              status_q <= 1'b1;
              state_q <= SOut;
            end else if (count_q == CntW'(Entries)) begin
              status_q <= 1'b1;
              state_q <= SOut;
            end else begin
              state_q <= SRecRd;
            end
          end else begin
            state_q <= SScanCmp;
          end
        end
        SScanCmp: begin
          if (key_rd == key_q) begin
            if (op_q == OpQuery) begin
              score_q <= scr_rd;
              state_q <= SOut;
            end else begin
              state_q <= SRecWr;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= SScanRd;
          end
        end
        SRecRd: state_q <= SRecWr;
        SRecWr: begin
          if (idx_q == count_q) count_q <= count_q + 1'b1;
          state_q <= SOut;
        end
        SRcRd: state_q <= (idx_q == count_q) ? SOut : SRcEval;
        SRcEval: begin
          if (dreq.start) begin
            state_q <= SRcDiv;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= SRcRd;
          end
        end
        SRcDiv: state_q <= SRcWait;
        SRcWait: if (drsp.done) begin
          idx_q <= idx_q + 1'b1;
          state_q <= SRcRd;
        end
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign score_o = score_q;
  assign status_o = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Entries))
    else $error("entry count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o && op_q == OpRecompute) |-> 1'b0)
    else $error("recompute flagged status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(score_o))
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !drsp.busy)
    else $error("divider busy while idle");
endmodule

// File: tb/relay_reliability_score_table_checker.sv
`timescale 1ns / 1ps

module relay_reliability_score_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_word_0_i,
  input  logic [63:0] key_word_1_i,
  input  logic [63:0] key_word_2_i,
  input  logic [63:0] key_word_3_i,
  input  logic        is_dns_i,
  input  logic [31:0] now_seconds_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [6:0]  score_i,
  input  logic [0:0]  status_i,
  input  logic        end_i,
  output int          fail_count_o
);
  import rrst_pkg::*;

  typedef struct packed {
    logic [6:0] score;
    logic       status;
  } score_rsp_t;

  logic [KeyW-1:0] peer_key     [Entries];
  logic [31:0]     tries        [Entries];
  logic [31:0]     wins         [Entries];
  logic [31:0]     timeouts     [Entries];
  logic [31:0]     dns_fails    [Entries];
  logic [31:0]     period_begin [Entries];
  logic [6:0]      peer_rating  [Entries];
  int unsigned     peer_total;
  logic [31:0]     window_len;
  score_rsp_t      rsp_fifo[$];
  int              mismatches;

  assign fail_count_o = mismatches + ((end_i) ? rsp_fifo.size() : 0);

  function automatic int find_peer(logic [KeyW-1:0] key);
    for (int i = 0; i < peer_total; i++) begin
      if (peer_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void rescore_all(logic [31:0] now);
    logic [32:0] deadline;
    logic [33:0] total;
    logic [63:0] raw;
    for (int i = 0; i < peer_total; i++) begin
      deadline = {1'b0, period_begin[i]} + {1'b0, window_len};
      if ({1'b0, now} > deadline) begin
        tries[i] = '0; wins[i] = '0; timeouts[i] = '0; dns_fails[i] = '0;
        period_begin[i] = now;
        peer_rating[i] = ScoreMax;
      end else if (tries[i] == 0) begin
        peer_rating[i] = ScoreMax;
      end else begin
        total = {2'b0, wins[i]} + {2'b0, timeouts[i]} + {1'b0, dns_fails[i], 1'b0};
        if (total == 0) begin
          peer_rating[i] = ScoreMax;
        end else begin
          raw = (64'd100 * {32'd0, wins[i]}) / {30'd0, total};
          peer_rating[i] = (raw > 100) ? ScoreMax : raw[6:0];
        end
      end
    end
  endfunction

  function automatic score_rsp_t apply_request(op_e op, logic [KeyW-1:0] key, logic dns,
                                               logic [31:0] now);
    score_rsp_t r;
    int idx;
    r = '0;
    case (op)
      OpSuccess, OpFailure: begin
        idx = find_peer(key);
        if (idx < 0 && peer_total < Entries) begin
          idx = peer_total;
          peer_key[idx] = key;
          tries[idx] = '0; wins[idx] = '0; timeouts[idx] = '0; dns_fails[idx] = '0;
          period_begin[idx] = now;
          peer_rating[idx] = ScoreMax;
          peer_total++;
        end
        if (idx < 0) begin
          r.status = 1'b1;
        end else begin
          tries[idx]++;
          if (op == OpSuccess) wins[idx]++;
          else if (dns) dns_fails[idx]++;
          else timeouts[idx]++;
        end
      end
      OpRecompute: rescore_all(now);
      default: begin
        idx = find_peer(key);
        if (idx < 0) begin
          r.score = ScoreMax;
          r.status = 1'b1;
        end else begin
          r.score = peer_rating[idx];
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_rsp_t exp_rsp;
    if (!rst_ni) begin
      peer_total = 0;
      window_len = WindowReset;
      rsp_fifo.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) window_len = cfg_data_i;
      // check the output first: in_ready stays low until the result transfers
      if (out_valid_i && out_ready_i) begin
        if (rsp_fifo.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          exp_rsp = rsp_fifo.pop_front();
          if (score_i !== exp_rsp.score) begin
            $error("score: expected %0d, got %0d", exp_rsp.score, score_i);
            mismatches++;
          end
          if (status_i !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, status_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        rsp_fifo.push_back(apply_request(op_e'(operation_i),
            {key_word_3_i, key_word_2_i, key_word_1_i, key_word_0_i},
            is_dns_i, now_seconds_i));
      end
    end
  end

endmodule

// File: tb/relay_reliability_score_table_unit_test.sv
`timescale 1ns / 1ps

module relay_reliability_score_table_unit_test;
  import rrst_pkg::*;

  localparam int PoolSize = 72;
  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OpQuery;
  logic [63:0] key_word_0_i = '0;
  logic [63:0] key_word_1_i = '0;
  logic [63:0] key_word_2_i = '0;
  logic [63:0] key_word_3_i = '0;
  logic        is_dns_i = 1'b0;
  logic [31:0] now_seconds_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [6:0]  score_o;
  logic [0:0]  status_o;
  logic        end_i = 1'b0;
  int          fail_count;

  logic [KeyW-1:0] key_pool [PoolSize];
  logic [31:0]     clock_now = '0;
  int              sent = 0;
  int              got = 0;
  int              burst_left = 0;
  int              hold_request = 0;
  int              idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  relay_reliability_score_table_unit dut (.*);

  relay_reliability_score_table_checker score_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .key_word_0_i, .key_word_1_i,
    .key_word_2_i, .key_word_3_i, .is_dns_i, .now_seconds_i,
    .out_valid_i(out_valid_o), .out_ready_i, .score_i(score_o), .status_i(status_o),
    .end_i, .fail_count_o(fail_count)
  );

  // receiver: stall pattern changes mode every so often; a long hold-off on request
  always @(posedge clk_i) begin
    int mode_left, mode, hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) got++;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_request(op_e op, logic [KeyW-1:0] key, logic dns, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    {key_word_3_i, key_word_2_i, key_word_1_i, key_word_0_i} <= key;
    is_dns_i <= dns;
    now_seconds_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic write_window(logic [31:0] value);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (got != sent) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    op_e op;
    logic [KeyW-1:0] key;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 40) ? OpSuccess : (pick < 70) ? OpFailure :
           (pick < 78) ? OpRecompute : OpQuery;
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, PoolSize - 1)];
      else key = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_now = $urandom;
      else if (pick < 4) clock_now = '1;
      else if (pick < 5) clock_now = '0;
      else clock_now = clock_now + $urandom_range(0, 3);
      if (n == count / 2) hold_request = 300;
      send_request(op, key, $urandom_range(0, 1), clock_now);
    end
  endtask

  initial begin
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom};
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unknown peer, extreme keys and times, expiry at the top of the time range
    send_request(OpQuery, '0, 1'b0, '0);
    send_request(OpSuccess, '0, 1'b0, '0);
    send_request(OpFailure, '1, 1'b1, '1);
    send_request(OpFailure, '1, 1'b0, '1);
    send_request(OpSuccess, '1, 1'b1, '1);
    send_request(OpQuery, '0, 1'b0, 32'd5);
    send_request(OpRecompute, '1, 1'b0, '0);
    send_request(OpQuery, '0, 1'b0, '0);
    send_request(OpQuery, '1, 1'b0, '0);
    send_request(OpRecompute, '0, 1'b1, '1);
    send_request(OpQuery, '0, 1'b0, '0);
    send_request(OpQuery, '1, 1'b1, '1);
    send_request(OpFailure, '0, 1'b0, '1);
    send_request(OpRecompute, '0, 1'b0, '1);
    send_request(OpQuery, '0, 1'b0, '1);

    write_window(32'd1);
    random_phase(110);
    write_window('1);
    random_phase(110);
    write_window($urandom_range(2, 60));
    random_phase(110);
    write_window(WindowReset);
    random_phase(110);

    in_valid_i <= 1'b0;
    while (got != sent) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    end_i <= 1'b1;
    @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rrst_pkg.sv
rtl/rrst_div.sv
rtl/relay_reliability_score_table_unit.sv
tb/relay_reliability_score_table_checker.sv
tb/relay_reliability_score_table_unit_test.sv
